// ----- hw/rtl/tpld_pkg.sv -----
`default_nettype none

package tpld_pkg;

    // Width of the per-word millisecond time base; all elapsed times wrap at this width.
    localparam int TIME_BITS = 32;

    localparam int CFG_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int LEVEL_BITS     = 3;
    localparam int COUNT_BITS     = 32;
    localparam int NUM_PROBES     = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_INTERVAL = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_TIME   = CFG_INDEX_BITS'(1);

    localparam logic [CFG_BITS-1:0] SAMPLE_INTERVAL_RESET = CFG_BITS'(10);
    localparam logic [CFG_BITS-1:0] DEBOUNCE_TIME_RESET   = CFG_BITS'(200);

    localparam logic [LEVEL_BITS-1:0] LVL_NONE  = LEVEL_BITS'(0);
    localparam logic [LEVEL_BITS-1:0] LVL_LOW   = LEVEL_BITS'(1);
    localparam logic [LEVEL_BITS-1:0] LVL_MID   = LEVEL_BITS'(2);
    localparam logic [LEVEL_BITS-1:0] LVL_HIGH  = LEVEL_BITS'(3);
    localparam logic [LEVEL_BITS-1:0] LVL_ERROR = LEVEL_BITS'(4);

    typedef logic [TIME_BITS-1:0] time_val_t;

    typedef struct packed {
        logic low_probe_raw;
        logic mid_probe_raw;
        logic high_probe_raw;
    } probe_word_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic [LEVEL_BITS-1:0] previous_level;
        logic                  level_changed;
        logic                  sampled;
        logic                  level_settled;
        logic                  low_probe_stable;
        logic                  mid_probe_stable;
        logic                  high_probe_stable;
        logic [COUNT_BITS-1:0] sample_count;
    } level_word_t;

    // Probe bits are 0 wet, 1 dry; index 0 is the low probe.
    function automatic logic [LEVEL_BITS-1:0] decode_level(input logic [NUM_PROBES-1:0] stable);
        logic [LEVEL_BITS-1:0] lvl;
        unique case (stable)
            3'b000:  lvl = LVL_HIGH;
            3'b100:  lvl = LVL_MID;
            3'b110:  lvl = LVL_LOW;
            3'b111:  lvl = LVL_NONE;
            default: lvl = LVL_ERROR;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/three_probe_level_debouncer_top.sv -----
// Three-probe water level debouncer.
//
// s_ channel: one word per 1 ms tick, carrying the raw low/mid/high probe pins
// (0 wet, 1 dry). m_ channel: exactly one result word per input word, with the
// decoded level, previous level, change/sample/settled flags, the debounced
// probe values and the running sample count.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write sample_interval (index 0)
// or debounce_time (index 1); other indexes are ignored. Write
// only while no word is in flight.
// Path: an accepted word is held in the input register, then moves on to the
// result register, from which the receiver takes it. Throughput: one word per
// cycle while m_ready is high; the per-word work is a handful of 32-bit
// subtract-and-compare paths between the input and result registers.
// Stall: when m_ready is low the result register holds; one more word can be
// taken into the input register, then s_ready drops until the result moves.
// Reset (aresetn low, synchronous): time base, sample count and level clear,
// probes read dry, registers return to 10 ms sample / 200 ms debounce.
`default_nettype none

module three_probe_level_debouncer_top (
    input  wire                               aclk,
    input  wire                               aresetn,

    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire tpld_pkg::probe_word_t        s_data,

    output logic                              m_valid,
    input  wire                               m_ready,
    output tpld_pkg::level_word_t             m_data,

    input  wire                               cfg_wr_en,
    input  wire [tpld_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire [tpld_pkg::CFG_BITS-1:0]      cfg_wdata
);
    import tpld_pkg::*;

    // Configuration registers
    logic [CFG_BITS-1:0] sample_interval_reg;
    logic [CFG_BITS-1:0] debounce_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_interval_reg <= SAMPLE_INTERVAL_RESET;
            debounce_time_reg   <= DEBOUNCE_TIME_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_wdata;
                CFG_DEBOUNCE_TIME:   debounce_time_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline control: input register feeding the result register
    logic        in_valid_reg;
    probe_word_t in_data_reg;
    logic        advance;
    logic        fire;

    assign advance = !m_valid || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Tracking state
    time_val_t                tick_time_reg,        tick_time_next;
    time_val_t                last_sample_reg,      last_sample_next;
    logic [NUM_PROBES-1:0]    cand_reg,             cand_next;
    logic [NUM_PROBES-1:0]    stable_reg,           stable_next;
    time_val_t                cand_start_reg [NUM_PROBES];
    time_val_t                cand_start_next[NUM_PROBES];
    logic [LEVEL_BITS-1:0]    level_reg,            level_next;
    logic [LEVEL_BITS-1:0]    prior_reg,            prior_next;
    time_val_t                change_time_reg,      change_time_next;
    logic [COUNT_BITS-1:0]    samples_reg,          samples_next;

    logic                     sample_now;
    logic                     changed;
    logic                     settled;
    logic [NUM_PROBES-1:0]    raw;
    logic [LEVEL_BITS-1:0]    decoded;
    time_val_t                debounce_ext;

    assign raw          = {in_data_reg.high_probe_raw, in_data_reg.mid_probe_raw,
                           in_data_reg.low_probe_raw};
    assign debounce_ext = TIME_BITS'(debounce_time_reg);

    always_comb begin
        tick_time_next   = tick_time_reg + TIME_BITS'(1);
        last_sample_next = last_sample_reg;
        cand_next        = cand_reg;
        stable_next      = stable_reg;
        for (int p = 0; p < NUM_PROBES; p++) begin
            cand_start_next[p] = cand_start_reg[p];
        end
        level_next       = level_reg;
        prior_next       = prior_reg;
        change_time_next = change_time_reg;
        samples_next     = samples_reg;
        changed          = 1'b0;

        sample_now = (tick_time_next - last_sample_reg) >= TIME_BITS'(sample_interval_reg);

        if (sample_now) begin
            last_sample_next = tick_time_next;
            // Per-probe debounce: a new value must be seen as candidate, then
            // confirmed at a later sample once debounce time has passed.
            for (int p = 0; p < NUM_PROBES; p++) begin
                if (raw[p] != stable_reg[p]) begin
                    if (raw[p] != cand_reg[p]) begin
                        cand_next[p]       = raw[p];
                        cand_start_next[p] = tick_time_next;
                    end else if ((tick_time_next - cand_start_reg[p]) >= debounce_ext) begin
                        stable_next[p] = raw[p];
                    end
                end else begin
                    cand_next[p] = raw[p];
                end
            end
            samples_next = samples_reg + COUNT_BITS'(1);
        end

        decoded = decode_level(stable_next);
        if (sample_now && (decoded != level_reg)) begin
            prior_next       = level_reg;
            level_next       = decoded;
            change_time_next = tick_time_next;
            changed          = 1'b1;
        end

        settled = (tick_time_next - change_time_next) >= debounce_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_time_reg   <= '0;
            last_sample_reg <= '0;
            cand_reg        <= '1;
            stable_reg      <= '1;
            for (int p = 0; p < NUM_PROBES; p++) begin
                cand_start_reg[p] <= '0;
            end
            level_reg       <= LVL_NONE;
            prior_reg       <= LVL_NONE;
            change_time_reg <= '0;
            samples_reg     <= '0;
        end else if (fire) begin
            tick_time_reg   <= tick_time_next;
            last_sample_reg <= last_sample_next;
            cand_reg        <= cand_next;
            stable_reg      <= stable_next;
            for (int p = 0; p < NUM_PROBES; p++) begin
                cand_start_reg[p] <= cand_start_next[p];
            end
            level_reg       <= level_next;
            prior_reg       <= prior_next;
            change_time_reg <= change_time_next;
            samples_reg     <= samples_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data.level             <= level_next;
            m_data.previous_level    <= prior_next;
            m_data.level_changed     <= changed;
            m_data.sampled           <= sample_now;
            m_data.level_settled     <= settled;
            m_data.low_probe_stable  <= stable_next[0];
            m_data.mid_probe_stable  <= stable_next[1];
            m_data.high_probe_stable <= stable_next[2];
            m_data.sample_count      <= samples_next;
        end
    end

endmodule

`default_nettype wire
